### rtl/assert_macros.svh
// assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

### rtl/bpa_pkg.sv
package bpa_pkg;
  localparam int unsigned Pages       = 4096;
  localparam int unsigned DirectPages = 1024;
  localparam int unsigned PageShift   = 12;
  localparam int unsigned Words       = Pages / 64;
  localparam int unsigned WordW       = $clog2(Words);
  localparam int unsigned DirWord     = DirectPages / 64;

  typedef enum logic [2:0] {
    CMD_ANY     = 3'd0,
    CMD_NAMED   = 3'd1,
    CMD_RUN     = 3'd2,
    CMD_FREE    = 3'd3,
    CMD_RESERVE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_R0_FIRST = 2'd0,
    REG_R0_END   = 2'd1,
    REG_R1_FIRST = 2'd2,
    REG_R1_END   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_DECODE, ST_RD, ST_MOD, ST_SCAN_RD, ST_SCAN,
    ST_RUN_RD, ST_RUN, ST_BACK_RD, ST_BACK, ST_DONE
  } state_e;

  // memory port request from the controller
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [WordW-1:0] addr;
    logic [63:0]      wdata;
  } mem_req_t;
endpackage

### rtl/bpa_bitmap_ram.sv
module bpa_bitmap_ram
  import bpa_pkg::*;
(
  input  logic        clk_i,
  input  mem_req_t    req_i,
  output logic [63:0] rdata_o
);
  logic [63:0] mem_q [Words];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.addr];
    end
  end
endmodule

### rtl/bitmap_page_allocator.sv
// Bitmap page allocator, first fit, 4096 pages in a 64 x 64-bit memory.
// Input channel (in_valid_i/in_ready_o) carries one item: cmd, page, amount.
// Output channel (out_valid_o/out_ready_i) returns one item per input:
// status (0 success) and page_addr (page << 12; zero on failure, free, reserve).
// Items are handled one at a time; each does read-modify-write on one memory
// word per page step. Named take, free and reserve pass through the decode,
// read, modify and done states. Take-any scans words from the boundary upward,
// with a read and a test state per word. A run reads and sets one page at a
// time, and when it fails it is rolled back page by page.
// After reset a clearing pass writes all 64 words with in_ready_o low;
// configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are taken any time
// and must only change while idle.
// The result is held in an output register; while the receiver stalls, no new
// item is accepted.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [11:0] page_i,
  input  logic [10:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [23:0] page_addr_o
);
  `include "assert_macros.svh"

  state_e state_q, state_d;
  logic [12:0] r0f_q, r0e_q, r1f_q, r1e_q;
  logic [2:0]  cmd_q;
  logic [11:0] page_q, page_d;
  logic [10:0] amt_q;
  logic [11:0] cur_q, cur_d;      // current page of run or rollback
  logic [WordW-1:0] wcnt_q, wcnt_d;
  logic        ok_q, ok_d;
  logic        ov_q, ov_d;
  logic [23:0] addr_d;
  logic [63:0] rdata;
  mem_req_t    req;
  logic [12:0] endp;
  logic        hit;
  logic [5:0]  fidx;
  logic        in_r0, in_r1;

  bpa_bitmap_ram u_ram (.clk_i, .req_i(req), .rdata_o(rdata));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0f_q <= 13'd0;
      r0e_q <= 13'(Pages);
      r1f_q <= 13'd0;
      r1e_q <= 13'd0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_R0_FIRST: r0f_q <= cfg_data_i;
        REG_R0_END:   r0e_q <= cfg_data_i;
        REG_R1_FIRST: r1f_q <= cfg_data_i;
        REG_R1_END:   r1e_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // lowest zero bit of the read word
  always_comb begin
    hit  = 1'b0;
    fidx = 6'd0;
    for (int k = 63; k >= 0; k--) begin
      if (!rdata[k]) begin
        hit  = 1'b1;
        fidx = 6'(k);
      end
    end
  end

  assign endp  = 13'(page_q) + 13'(amt_q);
  assign in_r0 = (r0f_q < 13'(page_q)) && (13'(page_q) + 13'd1 <= r0e_q);
  assign in_r1 = (r1f_q < 13'(page_q)) && (13'(page_q) + 13'd1 <= r1e_q);
  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;

  // controller
  always_comb begin
    state_d = state_q;
    page_d  = page_q;
    cur_d   = cur_q;
    wcnt_d  = wcnt_q;
    ok_d    = ok_q;
    ov_d    = ov_q;
    addr_d  = page_addr_o;
    req     = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        req.wr   = 1'b1;
        req.addr = wcnt_q;
        wcnt_d   = wcnt_q + 1'b1;
        if (wcnt_q == WordW'(Words - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = ST_DECODE;
          page_d  = page_i;
        end
      end
      ST_DECODE: begin
        ok_d    = 1'b0;
        state_d = ST_DONE;
        case (cmd_q)
          CMD_ANY: begin
            wcnt_d  = WordW'(DirWord);
            state_d = (DirWord < Words) ? ST_SCAN_RD : ST_DONE;
          end
          CMD_NAMED: if (page_q < 12'(DirectPages)) state_d = ST_RD;
          CMD_FREE:  if (in_r0 || in_r1) state_d = ST_RD;
          CMD_RESERVE: state_d = ST_RD;
          CMD_RUN: begin
            if (amt_q == 11'd0) ok_d = 1'b1;
            else if (amt_q <= 11'(DirectPages)) begin
              cur_d   = page_q;
              state_d = ST_RUN_RD;
            end
          end
          default: ;
        endcase
      end
      ST_RD: begin
        req.rd   = 1'b1;
        req.addr = page_q[11:6];
        state_d  = ST_MOD;
      end
      ST_MOD: begin
        req.addr  = page_q[11:6];
        req.wdata = rdata;
        state_d   = ST_DONE;
        if (cmd_q == CMD_FREE) begin
          req.wr = 1'b1;
          req.wdata[page_q[5:0]] = 1'b0;
          ok_d = 1'b1;
        end else if (cmd_q == CMD_RESERVE) begin
          req.wr = 1'b1;
          req.wdata[page_q[5:0]] = 1'b1;
          ok_d = 1'b1;
        end else if (!rdata[page_q[5:0]]) begin
          req.wr = 1'b1;
          req.wdata[page_q[5:0]] = 1'b1;
          ok_d = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        req.rd   = 1'b1;
        req.addr = wcnt_q;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        req.addr  = wcnt_q;
        req.wdata = rdata;
        if (hit) begin
          req.wr = 1'b1;
          req.wdata[fidx] = 1'b1;
          ok_d    = 1'b1;
          page_d  = {wcnt_q, fidx};
          state_d = ST_DONE;
        end else if (wcnt_q == WordW'(Words - 1)) begin
          state_d = ST_DONE;
        end else begin
          wcnt_d  = wcnt_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_RUN_RD: begin
        if (13'(cur_q) == endp) begin
          ok_d    = 1'b1;
          state_d = ST_DONE;
        end else if (cur_q >= 12'(DirectPages)) begin
          state_d = (cur_q == page_q) ? ST_DONE : ST_BACK_RD;
          cur_d   = cur_q - 1'b1;
        end else begin
          req.rd   = 1'b1;
          req.addr = cur_q[11:6];
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        req.addr  = cur_q[11:6];
        req.wdata = rdata;
        if (!rdata[cur_q[5:0]]) begin
          req.wr = 1'b1;
          req.wdata[cur_q[5:0]] = 1'b1;
          cur_d   = cur_q + 1'b1;
          state_d = ST_RUN_RD;
        end else if (cur_q == page_q) begin
          state_d = ST_DONE;
        end else begin
          cur_d   = cur_q - 1'b1;
          state_d = ST_BACK_RD;
        end
      end
      ST_BACK_RD: begin
        req.rd   = 1'b1;
        req.addr = cur_q[11:6];
        state_d  = ST_BACK;
      end
      ST_BACK: begin
        req.wr    = 1'b1;
        req.addr  = cur_q[11:6];
        req.wdata = rdata;
        req.wdata[cur_q[5:0]] = 1'b0;
        if (cur_q == page_q) state_d = ST_DONE;
        else begin
          cur_d   = cur_q - 1'b1;
          state_d = ST_BACK_RD;
        end
      end
      ST_DONE: begin
        ov_d    = 1'b1;
        addr_d  = (ok_q && (cmd_q == CMD_ANY || cmd_q == CMD_NAMED || cmd_q == CMD_RUN))
                  ? {page_q, {PageShift{1'b0}}} : 24'd0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wcnt_q  <= '0;
      ov_q    <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      ov_q    <= ov_d;
      ok_q    <= ok_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      amt_q <= amount_i;
    end
    page_q      <= page_d;
    cur_q       <= cur_d;
    page_addr_o <= addr_d;
    if (state_q == ST_DONE) status_o <= !ok_q;
  end

  `ASSERT_CLK(a_ready_idle, clk_i, rst_ni, !in_ready_o || state_q == ST_IDLE,
              "ready outside idle")
  `ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == ST_DONE, out_valid_o,
               "result not shown after done")
  `ASSERT_CLK(a_fail_zero, clk_i, rst_ni, !(out_valid_o && status_o) || page_addr_o == 24'd0,
              "failed result with nonzero address")
endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] page;
    logic [10:0] amount;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [23:0] page_addr;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [11:0] page_i;
  logic [10:0] amount_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic [23:0] page_addr_o;

  bitmap_page_allocator DUT (.*);

  // predictor copy of the allocator
  logic [Pages-1:0] used_map;
  logic [12:0]      region_first [2];
  logic [12:0]      region_end [2];

  request_t pending_q [$];
  grant_t   grant_q [$];
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       failed;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic bit page_is_used(int unsigned p);
    if (p >= Pages) return 1'b1;
    return used_map[p];
  endfunction

  function automatic bit in_region(int unsigned p, int r);
    return (region_first[r] < p) && (p + 1 <= region_end[r]);
  endfunction

  // work out the grant for one item and update the predicted bitmap
  function automatic grant_t allocate(request_t rq);
    grant_t      g;
    bit          ok;
    int unsigned i;
    int unsigned j;
    g.status = 1'b1;
    g.page_addr = '0;
    case (rq.cmd)
      CMD_ANY: begin
        for (i = DirectPages; i < Pages; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            g.status = 1'b0;
            g.page_addr = 24'(i << PageShift);
            break;
          end
        end
      end
      CMD_NAMED: begin
        if (rq.page < DirectPages && !used_map[rq.page]) begin
          used_map[rq.page] = 1'b1;
          g.status = 1'b0;
          g.page_addr = 24'(rq.page << PageShift);
        end
      end
      CMD_RUN: begin
        if (rq.amount <= DirectPages) begin
          ok = 1'b1;
          for (i = 0; i < rq.amount; i++) begin
            if (rq.page + i >= DirectPages || page_is_used(rq.page + i)) begin
              // roll back only what this run set
              for (j = 0; j < i; j++) used_map[rq.page + j] = 1'b0;
              ok = 1'b0;
              break;
            end
            used_map[rq.page + i] = 1'b1;
          end
          if (ok) begin
            g.status = 1'b0;
            g.page_addr = 24'(rq.page << PageShift);
          end
        end
      end
      CMD_FREE: begin
        if (in_region(rq.page, 0) || in_region(rq.page, 1)) begin
          used_map[rq.page] = 1'b0;
          g.status = 1'b0;
        end
      end
      CMD_RESERVE: begin
        used_map[rq.page] = 1'b1;
        g.status = 1'b0;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  // driver: feeds items from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= '0;
      page_i <= '0;
      amount_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        grant_q.push_back(allocate({cmd_i, page_i, amount_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          {cmd_i, page_i, amount_i} <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each item with the oldest expected grant
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (grant_q.size() == 0) begin
          $error("unexpected item: status %0d page_addr %h", status_o, page_addr_o);
          failed = 1'b1;
        end else begin
          grant_t g;
          g = grant_q.pop_front();
          if (status_o !== g.status) begin
            $error("status: expected %0d actual %0d", g.status, status_o);
            failed = 1'b1;
          end
          if (page_addr_o !== g.page_addr) begin
            $error("page_addr: expected %h actual %h", g.page_addr, page_addr_o);
            failed = 1'b1;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || grant_q.size() > 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [12:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_R0_FIRST: region_first[0] = value;
      REG_R0_END:   region_end[0] = value;
      REG_R1_FIRST: region_first[1] = value;
      REG_R1_END:   region_end[1] = value;
    endcase
  endtask

  task automatic push(logic [2:0] cmd, logic [11:0] page, logic [10:0] amount);
    pending_q.push_back({cmd, page, amount});
  endtask

  // mostly valid traffic with random content, some noise
  task automatic push_random(int count);
    int k;
    int sel;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 20) push(CMD_ANY, 12'($urandom), 11'($urandom));
      else if (sel < 38) push(CMD_NAMED, 12'($urandom_range(DirectPages + 40)), 11'($urandom));
      else if (sel < 52) begin
        if ($urandom_range(9) == 0)
          push(CMD_RUN, 12'($urandom), 11'($urandom));
        else
          push(CMD_RUN, 12'($urandom_range(DirectPages + 8)), 11'($urandom_range(12)));
      end else if (sel < 80) begin
        if ($urandom_range(1)) push(CMD_FREE, 12'($urandom_range(DirectPages + 200)), '0);
        else push(CMD_FREE, 12'($urandom), 11'($urandom));
      end else if (sel < 94) push(CMD_RESERVE, 12'($urandom), 11'($urandom));
      else push(3'($urandom_range(7, 5)), 12'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    int ph;
    failed = 1'b0;
    used_map = '0;
    region_first[0] = '0;
    region_end[0] = 13'd4096;
    region_first[1] = '0;
    region_end[1] = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_R0_FIRST;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every command, special cases
    push(CMD_ANY, '0, '0);
    push(CMD_ANY, 12'hfff, 11'h7ff);
    push(CMD_NAMED, 12'd0, '0);
    push(CMD_NAMED, 12'd0, '0);
    push(CMD_NAMED, 12'(DirectPages - 1), '0);
    push(CMD_NAMED, 12'(DirectPages), '0);
    push(CMD_NAMED, 12'hfff, 11'h7ff);
    push(CMD_RUN, 12'd10, 11'd4);
    push(CMD_RUN, 12'd8, 11'd4);
    push(CMD_RUN, 12'd100, 11'(DirectPages + 1));
    push(CMD_RUN, 12'hfff, 11'd0);
    push(CMD_RUN, 12'(DirectPages - 2), 11'd5);
    push(CMD_RUN, 12'd200, 11'd1);
    push(CMD_RUN, 12'd0, 11'h7ff);
    push(CMD_FREE, 12'd10, '0);
    push(CMD_FREE, 12'd0, '0);
    push(CMD_FREE, 12'hfff, '0);
    push(CMD_RESERVE, 12'hfff, '0);
    push(CMD_RESERVE, 12'(DirectPages), '0);
    push(CMD_ANY, '0, '0);
    push(3'd5, 12'd1, 11'd1);
    push(3'd7, 12'hfff, 11'h7ff);
    push(CMD_RUN, 12'd0, 11'(DirectPages));
    wait_drained();

    // several region settings with each idling mix
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0; recv_stall_pct = 0;
          write_reg(REG_R0_FIRST, 13'd0); write_reg(REG_R0_END, 13'd4096);
          write_reg(REG_R1_FIRST, 13'd0); write_reg(REG_R1_END, 13'd0);
        end
        1: begin
          send_idle_pct = 67; recv_stall_pct = 0;
          write_reg(REG_R0_FIRST, 13'd100); write_reg(REG_R0_END, 13'd600);
          write_reg(REG_R1_FIRST, 13'd1023); write_reg(REG_R1_END, 13'd1100);
        end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 67;
          write_reg(REG_R0_FIRST, 13'd4096); write_reg(REG_R0_END, 13'd0);
          write_reg(REG_R1_FIRST, 13'h1fff); write_reg(REG_R1_END, 13'h1fff);
        end
        default: begin
          send_idle_pct = 27; recv_stall_pct = 27;
          write_reg(REG_R0_FIRST, 13'd0); write_reg(REG_R0_END, 13'd1024);
          write_reg(REG_R1_FIRST, 13'd2000); write_reg(REG_R1_END, 13'd4096);
        end
      endcase
      push_random(450);
      wait_drained();
    end

    if (!failed) $display("bitmap_page_allocator regression: pass");
    else $display("bitmap_page_allocator regression: fail");
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("bitmap_page_allocator regression: fail");
    $finish;
  end
endmodule
